// ===== hw/rtl/graph_isomorphism_search_macros.svh =====
// Assertion macros for the graph isomorphism search block.
`ifndef GRAPH_ISOMORPHISM_SEARCH_MACROS_SVH
`define GRAPH_ISOMORPHISM_SEARCH_MACROS_SVH
`ifndef ASSERT_OFF
`define GIS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GIS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GIS_ASSERT(label, clk, rst_n, prop, msg)
`define GIS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/gis_pkg.sv =====
// ----------------------------------------------------------------------------
// gis_pkg
// Types, codes and sizing constants shared by the isomorphism search block.
// ----------------------------------------------------------------------------
package gis_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 8;
	localparam int unsigned COUNT_WIDTH_DEF  = 4;
	localparam int unsigned EDGE_WIDTH       = 10;
	localparam int unsigned VC_WIDTH         = 4;
	localparam int unsigned VTX_WIDTH        = 3;

	typedef enum logic [1:0] {
		MODE_EDGE_FIRST  = 2'd0,
		MODE_EDGE_SECOND = 2'd1,
		MODE_COMPARE     = 2'd2,
		MODE_CLEAR       = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DEG,
		ST_SORT,
		ST_DCMP,
		ST_MATCH,
		ST_NEXT_FIND,
		ST_NEXT_SWAP,
		ST_NEXT_REV,
		ST_EMIT,
		ST_FAIL
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic add_first;
		logic add_second;
		logic clr_step;
		logic clr_start;
		logic ident;
		logic deg_step;
		logic deg_start;
		logic sort_step;
		logic dcmp_step;
		logic match_step;
		logic match_start;
		logic find_step;
		logic find_start;
		logic swap_step;
		logic swap_do;
		logic rev_step;
		logic emit_start;
		logic emit_step;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic clr_done;
		logic edges_eq;
		logic deg_done;
		logic sort_done;
		logic dcmp_done;
		logic dcmp_ok;
		logic match_done;
		logic match_ok;
		logic find_done;
		logic find_none;
		logic swap_done;
		logic rev_done;
		logic emit_last;
	} sts_t;

endpackage

// ===== hw/rtl/graph_isomorphism_search.sv =====
// Edge items may follow back to back; a clear item passes through the clear state.
// A compare computes and sorts the degree lists of both graphs and compares them,
// then tries permutations with the row-serial match and permutation units.
// Results then leave one per cycle while out_ready is high; one compare runs at a time.
// Reset clears both stores and edge counters, sets the permutation to identity and the count to 8.
// ----------------------------------------------------------------------------
// graph_isomorphism_search
// Brute-force isomorphism test of two small undirected multigraphs.
// ----------------------------------------------------------------------------
`include "graph_isomorphism_search_macros.svh"

module graph_isomorphism_search #(
	parameter int unsigned MAX_VERTICES = gis_pkg::MAX_VERTICES_DEF,
	parameter int unsigned COUNT_WIDTH  = gis_pkg::COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [2:0] end_a,
	input  logic [2:0] end_b,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_isomorphic,
	output logic [2:0] vertex_index,
	output logic [2:0] mapped_vertex,
	output logic       last
);

	logic [3:0]    vertex_count_q;
	gis_pkg::cmd_t cmd;
	gis_pkg::sts_t sts;
	logic          out_load, out_ok;
	logic [2:0]    emit_index, emit_mapped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vertex_count_q <= 4'd8;
		else if (cfg_we) vertex_count_q <= cfg_wdata;
	end

	gis_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .out_valid(out_valid), .out_ready(out_ready),
		.out_load(out_load), .out_ok(out_ok), .cmd(cmd), .sts(sts)
	);

	gis_datapath #(.MAX_VERTICES(MAX_VERTICES), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .vertex_count_q(vertex_count_q),
		.end_a(end_a), .end_b(end_b), .cmd(cmd), .sts(sts),
		.emit_index(emit_index), .emit_mapped(emit_mapped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			is_isomorphic <= out_ok;
			vertex_index  <= out_ok ? emit_index : 3'd0;
			mapped_vertex <= out_ok ? emit_mapped : 3'd0;
			last          <= out_ok ? sts.emit_last : 1'b1;
		end
	end

	`GIS_ASSERT(a_load_free, clk, arst_n, out_load |-> (!out_valid || out_ready), "result overwritten")
	`GIS_ASSERT(a_busy, clk, arst_n, out_load |-> !in_ready, "input taken while emitting")
	`GIS_ASSERT(a_fail_last, clk, arst_n, (out_valid && !is_isomorphic) |-> last, "failure not last")

endmodule

// ===== hw/rtl/gis_ctrl.sv =====
// ----------------------------------------------------------------------------
// gis_ctrl
// Sequencer for edge loading, clearing and the permutation search.
// ----------------------------------------------------------------------------
module gis_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       mode,
	input  logic             out_valid,
	input  logic             out_ready,
	output logic             out_load,
	output logic             out_ok,
	output gis_pkg::cmd_t    cmd,
	input  gis_pkg::sts_t    sts
);

	gis_pkg::state_t state_q, state_d;
	logic            acc;

	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gis_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The output register holds one result; a new one is loaded when it is
	// empty or being taken in this cycle.
	logic slot_free;
	assign slot_free = !out_valid || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		out_ok   = 1'b0;
		case (state_q)
			gis_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (acc) begin
					case (gis_pkg::mode_t'(mode))
						gis_pkg::MODE_EDGE_FIRST:  cmd.add_first = 1'b1;
						gis_pkg::MODE_EDGE_SECOND: cmd.add_second = 1'b1;
						gis_pkg::MODE_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d = gis_pkg::ST_CLEAR;
						end
						gis_pkg::MODE_COMPARE: begin
							cmd.ident = 1'b1;
							cmd.deg_start = 1'b1;
							state_d = gis_pkg::ST_DEG;
						end
						default: ;
					endcase
				end
			end
			gis_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = gis_pkg::ST_IDLE;
			end
			gis_pkg::ST_DEG: begin
				if (!sts.edges_eq) begin
					state_d = gis_pkg::ST_FAIL;
				end else begin
					cmd.deg_step = 1'b1;
					if (sts.deg_done) state_d = gis_pkg::ST_SORT;
				end
			end
			gis_pkg::ST_SORT: begin
				cmd.sort_step = 1'b1;
				if (sts.sort_done) state_d = gis_pkg::ST_DCMP;
			end
			gis_pkg::ST_DCMP: begin
				cmd.dcmp_step = 1'b1;
				if (!sts.dcmp_ok) begin
					state_d = gis_pkg::ST_FAIL;
				end else if (sts.dcmp_done) begin
					cmd.match_start = 1'b1;
					state_d = gis_pkg::ST_MATCH;
				end
			end
			gis_pkg::ST_MATCH: begin
				if (!sts.match_ok) begin
					cmd.find_start = 1'b1;
					state_d = gis_pkg::ST_NEXT_FIND;
				end else if (sts.match_done) begin
					cmd.emit_start = 1'b1;
					state_d = gis_pkg::ST_EMIT;
				end else begin
					cmd.match_step = 1'b1;
				end
			end
			gis_pkg::ST_NEXT_FIND: begin
				cmd.find_step = 1'b1;
				if (sts.find_done) begin
					state_d = sts.find_none ? gis_pkg::ST_NEXT_REV
					                        : gis_pkg::ST_NEXT_SWAP;
				end
			end
			gis_pkg::ST_NEXT_SWAP: begin
				cmd.swap_step = 1'b1;
				if (sts.swap_done) begin
					cmd.swap_do = 1'b1;
					state_d = gis_pkg::ST_NEXT_REV;
				end
			end
			gis_pkg::ST_NEXT_REV: begin
				cmd.rev_step = 1'b1;
				if (sts.rev_done) begin
					if (sts.find_none) begin
						state_d = gis_pkg::ST_FAIL;
					end else begin
						cmd.match_start = 1'b1;
						state_d = gis_pkg::ST_MATCH;
					end
				end
			end
			gis_pkg::ST_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_ok = 1'b1;
					cmd.emit_step = 1'b1;
					if (sts.emit_last) state_d = gis_pkg::ST_IDLE;
				end
			end
			gis_pkg::ST_FAIL: begin
				if (slot_free) begin
					out_load = 1'b1;
					cmd.ident = 1'b1;
					state_d = gis_pkg::ST_IDLE;
				end
			end
			default: state_d = gis_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/gis_datapath.sv =====
// ----------------------------------------------------------------------------
// gis_datapath
// Adjacency stores, edge counters, degree lists and permutation register.
// ----------------------------------------------------------------------------
`include "graph_isomorphism_search_macros.svh"

module gis_datapath #(
	parameter int unsigned MAX_VERTICES = gis_pkg::MAX_VERTICES_DEF,
	parameter int unsigned COUNT_WIDTH  = gis_pkg::COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [gis_pkg::VC_WIDTH-1:0] vertex_count_q,
	input  logic [gis_pkg::VTX_WIDTH-1:0] end_a,
	input  logic [gis_pkg::VTX_WIDTH-1:0] end_b,
	input  gis_pkg::cmd_t                cmd,
	output gis_pkg::sts_t                sts,
	output logic [gis_pkg::VTX_WIDTH-1:0] emit_index,
	output logic [gis_pkg::VTX_WIDTH-1:0] emit_mapped
);

	localparam int unsigned VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int unsigned NW    = $clog2(MAX_VERTICES + 1);
	localparam int unsigned ROWW  = MAX_VERTICES * COUNT_WIDTH;
	localparam int unsigned DW    = COUNT_WIDTH + NW;
	localparam int unsigned EW    = gis_pkg::EDGE_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] CELL_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [EW-1:0] EDGE_MAX = {EW{1'b1}};
	localparam logic [NW-1:0] NMAX = NW'(MAX_VERTICES);

	// Used vertex count, clamped to 1 .. MAX_VERTICES.
	logic [NW-1:0] n;
	always_comb begin
		if (vertex_count_q == '0) n = NW'(1);
		else if (32'(vertex_count_q) > MAX_VERTICES) n = NMAX;
		else n = NW'(vertex_count_q);
	end
	logic [VW-1:0] nm1;
	assign nm1 = VW'(n - NW'(1));

	// Adjacency stores: one packed word of cells per row.
	logic [ROWW-1:0] adj1_q [MAX_VERTICES];
	logic [ROWW-1:0] adj2_q [MAX_VERTICES];
	logic [EW-1:0] edges1_q, edges2_q;
	logic edge_ok;
	assign edge_ok = (NW'(end_a) < n) && (NW'(end_b) < n);

	function automatic logic [COUNT_WIDTH-1:0] cell_of(input logic [ROWW-1:0] row,
		input logic [VW-1:0] c);
		return row[32'(c) * COUNT_WIDTH +: COUNT_WIDTH];
	endfunction

	logic [VW-1:0] va, vb;
	logic [COUNT_WIDTH-1:0] c1ab, c1ba, c2ab, c2ba;
	assign va = VW'(end_a);
	assign vb = VW'(end_b);
	assign c1ab = cell_of(adj1_q[va], vb);
	assign c1ba = cell_of(adj1_q[vb], va);
	assign c2ab = cell_of(adj2_q[va], vb);
	assign c2ba = cell_of(adj2_q[vb], va);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_VERTICES; k++) begin
				adj1_q[k] <= '0;
				adj2_q[k] <= '0;
			end
			edges1_q <= '0;
			edges2_q <= '0;
		end else if (cmd.clr_start) begin
			for (int k = 0; k < MAX_VERTICES; k++) begin
				adj1_q[k] <= '0;
				adj2_q[k] <= '0;
			end
			edges1_q <= '0;
			edges2_q <= '0;
		end else if (cmd.add_first && edge_ok) begin
			if (c1ab != CELL_MAX)
				adj1_q[va][32'(vb) * COUNT_WIDTH +: COUNT_WIDTH] <= c1ab + 1'b1;
			if (end_a != end_b && c1ba != CELL_MAX)
				adj1_q[vb][32'(va) * COUNT_WIDTH +: COUNT_WIDTH] <= c1ba + 1'b1;
			if (edges1_q != EDGE_MAX) edges1_q <= edges1_q + 1'b1;
		end else if (cmd.add_second && edge_ok) begin
			if (c2ab != CELL_MAX)
				adj2_q[va][32'(vb) * COUNT_WIDTH +: COUNT_WIDTH] <= c2ab + 1'b1;
			if (end_a != end_b && c2ba != CELL_MAX)
				adj2_q[vb][32'(va) * COUNT_WIDTH +: COUNT_WIDTH] <= c2ba + 1'b1;
			if (edges2_q != EDGE_MAX) edges2_q <= edges2_q + 1'b1;
		end
	end

	assign sts.clr_done = 1'b1;
	assign sts.edges_eq = (edges1_q == edges2_q);

	// Degrees: one row per cycle, unused entries forced to the maximum so that
	// they sort to the top and compare equal.
	logic [DW-1:0] deg1_q [MAX_VERTICES];
	logic [DW-1:0] deg2_q [MAX_VERTICES];
	logic [VW-1:0] row_q;
	logic [DW-1:0] rsum1, rsum2;
	always_comb begin
		rsum1 = '0;
		rsum2 = '0;
		for (int c = 0; c < MAX_VERTICES; c++) begin
			if (NW'(c) < n) begin
				rsum1 = rsum1 + DW'(cell_of(adj1_q[row_q], VW'(c)));
				rsum2 = rsum2 + DW'(cell_of(adj2_q[row_q], VW'(c)));
			end
		end
	end
	assign sts.deg_done = (row_q == VW'(MAX_VERTICES - 1));

	// Odd-even transposition sort of both degree lists.
	logic [NW-1:0] sort_q;
	logic          phase_q;
	assign sts.sort_done = (sort_q == NMAX);

	always_ff @(posedge clk) begin
		if (cmd.deg_start) begin
			row_q  <= '0;
			sort_q <= '0;
			phase_q <= 1'b0;
		end else if (cmd.deg_step) begin
			deg1_q[row_q] <= (NW'(row_q) < n) ? rsum1 : {DW{1'b1}};
			deg2_q[row_q] <= (NW'(row_q) < n) ? rsum2 : {DW{1'b1}};
			if (!sts.deg_done) row_q <= row_q + 1'b1;
		end else if (cmd.sort_step) begin
			for (int k = 0; k + 1 < MAX_VERTICES; k++) begin
				if ((k % 2) == int'(phase_q)) begin
					if (deg1_q[k] > deg1_q[k+1]) begin
						deg1_q[k] <= deg1_q[k+1];
						deg1_q[k+1] <= deg1_q[k];
					end
					if (deg2_q[k] > deg2_q[k+1]) begin
						deg2_q[k] <= deg2_q[k+1];
						deg2_q[k+1] <= deg2_q[k];
					end
				end
			end
			phase_q <= ~phase_q;
			sort_q  <= sort_q + 1'b1;
		end
	end

	// Degree compare, one entry per cycle.
	logic [VW-1:0] dc_q;
	always_ff @(posedge clk) begin
		if (cmd.deg_start) dc_q <= '0;
		else if (cmd.dcmp_step && !sts.dcmp_done) dc_q <= dc_q + 1'b1;
	end
	assign sts.dcmp_ok   = (deg1_q[dc_q] == deg2_q[dc_q]);
	assign sts.dcmp_done = (dc_q == nm1);

	// Permutation register.
	logic [VW-1:0] perm_q [MAX_VERTICES];

	// Match check: one row of the first graph per cycle.
	logic [VW-1:0] mrow_q;
	logic          row_ok;
	always_comb begin
		row_ok = 1'b1;
		for (int c = 0; c < MAX_VERTICES; c++) begin
			if (NW'(c) < n &&
			    cell_of(adj1_q[mrow_q], VW'(c)) != cell_of(adj2_q[perm_q[mrow_q]], perm_q[c]))
				row_ok = 1'b0;
		end
	end
	assign sts.match_ok   = row_ok;
	assign sts.match_done = (mrow_q == nm1);

	// Next permutation: find pivot, find successor, swap, reverse suffix.
	logic [VW-1:0] fi_q;   // candidate i (suffix start)
	logic [VW-1:0] fj_q;
	logic [VW-1:0] lo_q, hi_q;
	logic [VW:0]   fi_w;
	assign sts.find_done = (fi_q == '0) || (perm_q[fi_q - 1'b1] < perm_q[fi_q]);
	// A suffix start of zero means the last permutation has been passed.
	assign sts.find_none = (fi_q == '0);
	assign sts.swap_done = (perm_q[fj_q] > perm_q[fi_q - 1'b1]);
	assign sts.rev_done  = !(lo_q < hi_q);
	assign fi_w = {1'b0, fi_q};

	logic [VW-1:0] em_q;
	assign sts.emit_last = (em_q == nm1);
	assign emit_index  = gis_pkg::VTX_WIDTH'(em_q);
	assign emit_mapped = gis_pkg::VTX_WIDTH'(perm_q[em_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_VERTICES; k++) perm_q[k] <= VW'(k);
			fi_q <= '0;
			fj_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
		end else if (cmd.ident || cmd.clr_start) begin
			for (int k = 0; k < MAX_VERTICES; k++) perm_q[k] <= VW'(k);
		end else if (cmd.find_start) begin
			fi_q <= nm1;
			fj_q <= nm1;
			hi_q <= nm1;
		end else if (cmd.find_step) begin
			if (sts.find_done) begin
				lo_q <= fi_q;
			end else begin
				fi_q <= fi_q - 1'b1;
			end
		end else if (cmd.swap_do) begin
			perm_q[fi_q - 1'b1] <= perm_q[fj_q];
			perm_q[fj_q] <= perm_q[fi_q - 1'b1];
		end else if (cmd.swap_step) begin
			fj_q <= fj_q - 1'b1;
		end else if (cmd.rev_step && !sts.rev_done) begin
			perm_q[lo_q] <= perm_q[hi_q];
			perm_q[hi_q] <= perm_q[lo_q];
			lo_q <= lo_q + 1'b1;
			hi_q <= hi_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match_start) mrow_q <= '0;
		else if (cmd.match_step) mrow_q <= mrow_q + 1'b1;
		if (cmd.emit_start) em_q <= '0;
		else if (cmd.emit_step) em_q <= em_q + 1'b1;
	end

	`GIS_ASSERT(a_fi_range, clk, arst_n, cmd.find_step |-> (fi_w <= {1'b0, nm1}), "pivot index out of range")
	`GIS_ASSERT(a_swap_ord, clk, arst_n, cmd.swap_do |-> (fi_q != '0), "swap without pivot")
	`GIS_ASSERT(a_excl, clk, arst_n, cmd.add_first |-> !cmd.add_second, "two stores written at once")

endmodule
